FILE: src/kdes_pkg.sv
// Package for the key debounce event scanner: widths, reset values,
// event and register codes, and the lane result and lane config types.
// No dependencies.
package kdes_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int MAX_EVENTS   = 8;
  localparam int DB_W         = 8;
  localparam int HOLD_W       = 16;
  localparam int EV_W         = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int LANE_SLOTS   = 2;

  localparam logic [DB_W-1:0]   DEBOUNCE_RST  = 8'd3;
  localparam logic [HOLD_W-1:0] LONG_RST      = 16'd50;
  localparam logic [HOLD_W-1:0] REP_START_RST = 16'd70;
  localparam logic [HOLD_W-1:0] REP_RATE_RST  = 16'd12;

  typedef enum logic [EV_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_SHORT   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE  = 3'd0,
    CFG_LONG      = 3'd1,
    CFG_REP_START = 3'd2,
    CFG_REP_RATE  = 3'd3,
    CFG_ACT_LOW   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                             pressed;
    logic [LANE_SLOTS-1:0]            vld;
    logic [LANE_SLOTS-1:0][EV_W-1:0]  kind;
  } lane_res_t;

  typedef struct packed {
    logic [DB_W-1:0]   debounce;
    logic [HOLD_W-1:0] long_ticks;
    logic [HOLD_W-1:0] rep_start;
    logic [HOLD_W-1:0] rep_rate;
  } key_cfg_t;

endpackage

FILE: src/key_debounce_event_scanner.sv
// Top level of the key debounce event scanner: config registers, key lanes,
// merge stage and sequencing. Depends on kdes_pkg, kdes_lane and kdes_merge.
//
// Each input transaction is one scan tick with the raw pin level of every key.
// All key lanes update their debounce, press and hold state in the accept
// cycle, then run their repeat-interval remainder unit in parallel (16-bit
// hold offset, two bits per cycle, then a registered done flag). The merge
// stage then visits two event slots per key, one slot per cycle, and emits
// events in key order through an output register; a stalled output pauses the
// walk. The next tick is accepted once the walk ends, while the last event may
// still wait in the output register. Config writes are registered and must be
// made between ticks; a repeat_rate of zero acts as one.
module key_debounce_event_scanner #(
  parameter int NUM_KEYS = kdes_pkg::NUM_KEYS_DEF,
  localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kdes_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kdes_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [NUM_KEYS-1:0]             raw_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [KEY_W-1:0]                key_index_o,
  output logic [kdes_pkg::EV_W-1:0]       event_kind_o,
  output logic [NUM_KEYS-1:0]             down_mask_o,
  output logic                            last_of_tick_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_MERGE
  } state_e;

  state_e                         state_q;
  logic [kdes_pkg::DB_W-1:0]      debounce_q;
  logic [kdes_pkg::HOLD_W-1:0]    long_q;
  logic [kdes_pkg::HOLD_W-1:0]    rep_start_q;
  logic [kdes_pkg::HOLD_W-1:0]    rep_rate_q;
  logic [NUM_KEYS-1:0]            act_low_q;

  kdes_pkg::key_cfg_t             key_cfg;
  kdes_pkg::lane_res_t            lane_res [NUM_KEYS];
  logic [NUM_KEYS-1:0]            lane_done;
  logic                           in_accept;
  logic                           merge_start;
  logic                           merge_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= kdes_pkg::DEBOUNCE_RST;
      long_q      <= kdes_pkg::LONG_RST;
      rep_start_q <= kdes_pkg::REP_START_RST;
      rep_rate_q  <= kdes_pkg::REP_RATE_RST;
      act_low_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kdes_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_wdata_i[kdes_pkg::DB_W-1:0];
        kdes_pkg::CFG_LONG:      long_q      <= cfg_wdata_i[kdes_pkg::HOLD_W-1:0];
        kdes_pkg::CFG_REP_START: rep_start_q <= cfg_wdata_i[kdes_pkg::HOLD_W-1:0];
        kdes_pkg::CFG_REP_RATE:  rep_rate_q  <= cfg_wdata_i[kdes_pkg::HOLD_W-1:0];
        kdes_pkg::CFG_ACT_LOW:   act_low_q   <= cfg_wdata_i[NUM_KEYS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    key_cfg.debounce   = debounce_q;
    key_cfg.long_ticks = long_q;
    key_cfg.rep_start  = rep_start_q;
    key_cfg.rep_rate   = (rep_rate_q == '0) ? kdes_pkg::HOLD_W'(1) : rep_rate_q;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign merge_start = (state_q == S_RUN) && lane_done[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (lane_done[0]) begin
            state_q <= S_MERGE;
          end
        end
        S_MERGE: begin
          if (!merge_busy) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kdes_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (in_accept),
      .raw_i   (raw_levels_i[k]),
      .pol_i   (act_low_q[k]),
      .cfg_i   (key_cfg),
      .res_o   (lane_res[k]),
      .done_o  (lane_done[k])
    );
  end

  kdes_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (merge_start),
    .res_i          (lane_res),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .key_index_o    (key_index_o),
    .event_kind_o   (event_kind_o),
    .down_mask_o    (down_mask_o),
    .last_of_tick_o (last_of_tick_o),
    .busy_o         (merge_busy)
  );

`ifndef SYNTHESIS
  a_merge_in_merge_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_busy |-> (state_q == S_MERGE))
    else $error("merge stage busy outside merge phase");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&lane_done) == (|lane_done))
    else $error("key lanes finished out of step");

  a_lane_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done[0] |-> (state_q == S_RUN))
    else $error("lane finished outside run phase");

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_RUN) && !merge_busy)
    else $error("accepted transaction did not start the lanes");
`endif

endmodule

FILE: src/kdes_rem.sv
// Remainder unit: restoring division, two quotient bits per cycle.
// Flags a zero remainder of the hold offset by the repeat rate. Uses kdes_pkg.
module kdes_rem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kdes_pkg::HOLD_W-1:0] dividend_i,
  input  logic [kdes_pkg::HOLD_W-1:0] divisor_i,
  output logic                        done_o,
  output logic                        rem_zero_o
);

  localparam int W     = kdes_pkg::HOLD_W;
  localparam int STEPS = W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [W-1:0]     num_q;
  logic [W-1:0]     rem_q;
  logic [W-1:0]     div_q;
  logic [W-1:0]     rem_d;
  logic [W:0]       r1;
  logic [W:0]       r2;

  always_comb begin
    r1 = {rem_q, num_q[W-1]};
    if (r1 >= {1'b0, div_q}) begin
      r1 = r1 - {1'b0, div_q};
    end
    r2 = {r1[W-1:0], num_q[W-2]};
    if (r2 >= {1'b0, div_q}) begin
      r2 = r2 - {1'b0, div_q};
    end
    rem_d = r2[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[W-3:0], 2'b00};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign rem_zero_o = (rem_q == '0);

endmodule

FILE: src/kdes_lane.sv
// One key lane: debounce, press state, hold counter and long/repeat decision.
// Depends on kdes_pkg and kdes_rem.
module kdes_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 raw_i,
  input  logic                 pol_i,
  input  kdes_pkg::key_cfg_t   cfg_i,
  output kdes_pkg::lane_res_t  res_o,
  output logic                 done_o
);

  localparam int DB_W   = kdes_pkg::DB_W;
  localparam int HOLD_W = kdes_pkg::HOLD_W;

  logic                prev_q, prev_d;
  logic [DB_W-1:0]     cnt_q, cnt_d;
  logic                pressed_q, pressed_d;
  logic [HOLD_W-1:0]   hold_q, hold_d, hold_base;
  logic                long_q, long_d, long_base;
  logic                rep_cand_q, rep_cand_d;
  kdes_pkg::lane_res_t res_q, res_d;

  logic                sample;
  logic                key_chg;
  logic                long_hit;
  logic [HOLD_W-1:0]   diff;
  logic                rem_done;
  logic                rem_zero;

  always_comb begin
    sample = raw_i ^ pol_i;
    if (sample == prev_q) begin
      prev_d = prev_q;
      cnt_d  = (cnt_q < cfg_i.debounce) ? cnt_q + 1'b1 : cnt_q;
    end else begin
      prev_d = sample;
      cnt_d  = '0;
    end

    key_chg   = (cnt_d >= cfg_i.debounce) && (sample != pressed_q);
    pressed_d = key_chg ? sample : pressed_q;
    hold_base = (key_chg && sample) ? '0 : hold_q;
    long_base = (key_chg && sample) ? 1'b0 : long_q;
    hold_d    = pressed_d ? hold_base + 1'b1 : hold_base;

    long_hit   = pressed_d && !long_base && (hold_d >= cfg_i.long_ticks);
    long_d     = long_base | long_hit;
    rep_cand_d = pressed_d && long_base && (hold_d >= cfg_i.rep_start);
    diff       = hold_d - cfg_i.rep_start;

    res_d.pressed = pressed_d;
    res_d.vld     = '0;
    res_d.kind[0] = kdes_pkg::EV_PRESS;
    res_d.kind[1] = kdes_pkg::EV_LONG;
    if (key_chg && sample) begin
      res_d.vld[0] = 1'b1;
      res_d.vld[1] = long_hit;
    end else if (key_chg) begin
      if (!long_q) begin
        res_d.vld     = 2'b11;
        res_d.kind[0] = kdes_pkg::EV_SHORT;
        res_d.kind[1] = kdes_pkg::EV_RELEASE;
      end else begin
        res_d.vld[0]  = 1'b1;
        res_d.kind[0] = kdes_pkg::EV_RELEASE;
      end
    end else if (long_hit) begin
      res_d.vld[0]  = 1'b1;
      res_d.kind[0] = kdes_pkg::EV_LONG;
    end
  end

  kdes_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .dividend_i (diff),
    .divisor_i  (cfg_i.rep_rate),
    .done_o     (rem_done),
    .rem_zero_o (rem_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b0;
      cnt_q      <= '0;
      pressed_q  <= 1'b0;
      hold_q     <= '0;
      long_q     <= 1'b0;
      rep_cand_q <= 1'b0;
      res_q      <= '0;
    end else if (start_i) begin
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
      pressed_q  <= pressed_d;
      hold_q     <= hold_d;
      long_q     <= long_d;
      rep_cand_q <= rep_cand_d;
      res_q      <= res_d;
    end else if (rem_done && rep_cand_q && rem_zero) begin
      res_q.vld[0]  <= 1'b1;
      res_q.kind[0] <= kdes_pkg::EV_REPEAT;
    end
  end

  assign res_o  = res_q;
  assign done_o = rem_done;

endmodule

FILE: src/kdes_merge.sv
// Merge stage: walks the lane event slots in key order and drives the
// output register, marking the final event of the tick. Uses kdes_pkg.
module kdes_merge #(
  parameter int NUM_KEYS = kdes_pkg::NUM_KEYS_DEF,
  localparam int KEY_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  kdes_pkg::lane_res_t       res_i [NUM_KEYS],
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [KEY_W-1:0]          key_index_o,
  output logic [kdes_pkg::EV_W-1:0] event_kind_o,
  output logic [NUM_KEYS-1:0]       down_mask_o,
  output logic                      last_of_tick_o,
  output logic                      busy_o
);

  localparam int NSLOT  = kdes_pkg::LANE_SLOTS * NUM_KEYS;
  localparam int SLOT_W = KEY_W + 1;
  localparam int CNT_W  = $clog2(kdes_pkg::MAX_EVENTS + 1);

  logic                      busy_q;
  logic [SLOT_W-1:0]         ptr_q;
  logic [CNT_W-1:0]          emit_cnt_q;
  logic                      out_vld_q;
  logic [KEY_W-1:0]          key_q;
  logic [kdes_pkg::EV_W-1:0] kind_q;
  logic [NUM_KEYS-1:0]       mask_q;
  logic                      last_q;

  logic [NSLOT-1:0]                      vld_flat;
  logic [NSLOT-1:0][kdes_pkg::EV_W-1:0]  kind_flat;
  logic [NUM_KEYS-1:0]                   mask;
  logic                                  cur_vld;
  logic                                  later_vld;
  logic                                  step;

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      mask[k] = res_i[k].pressed;
      for (int s = 0; s < kdes_pkg::LANE_SLOTS; s++) begin
        vld_flat[k*kdes_pkg::LANE_SLOTS + s]  = res_i[k].vld[s];
        kind_flat[k*kdes_pkg::LANE_SLOTS + s] = res_i[k].kind[s];
      end
    end
    later_vld = 1'b0;
    for (int j = 0; j < NSLOT; j++) begin
      if (SLOT_W'(j) > ptr_q) begin
        later_vld = later_vld | vld_flat[j];
      end
    end
    cur_vld = vld_flat[ptr_q] && (emit_cnt_q < CNT_W'(kdes_pkg::MAX_EVENTS));
    step    = busy_q && (!out_vld_q || out_ready_i || !cur_vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      ptr_q      <= '0;
      emit_cnt_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (start_i) begin
        busy_q     <= 1'b1;
        ptr_q      <= '0;
        emit_cnt_q <= '0;
      end else if (step) begin
        if (cur_vld) begin
          emit_cnt_q <= emit_cnt_q + 1'b1;
        end
        if (ptr_q == SLOT_W'(NSLOT - 1)) begin
          busy_q <= 1'b0;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (step && cur_vld) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && cur_vld) begin
      key_q  <= ptr_q[SLOT_W-1:1];
      kind_q <= kind_flat[ptr_q];
      mask_q <= mask;
      last_q <= !later_vld || (emit_cnt_q == CNT_W'(kdes_pkg::MAX_EVENTS - 1));
    end
  end

  assign out_valid_o    = out_vld_q;
  assign key_index_o    = key_q;
  assign event_kind_o   = kind_q;
  assign down_mask_o    = mask_q;
  assign last_of_tick_o = last_q;
  assign busy_o         = busy_q;

endmodule
